/* src/skl_pkg.sv */
// Shared constants and types for the sorted key list.
`default_nettype none

package skl_pkg;

   // Default sizes
   localparam int CAPACITY_DEF = 16;
   localparam int KEY_BITS_DEF = 32;

   // Operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // Update command broadcast to every cell
   typedef struct packed {
      logic ins;  // insert the probe key at its sorted place
      logic rem;  // delete the first equal key
   } cmd_type;

   // Compare flags returned by each cell
   typedef struct packed {
      logic lt;      // occupied and stored key below probe key
      logic at_pos;  // first cell that is not below the probe key
      logic hit;     // at_pos, occupied and equal
   } flag_type;

endpackage

`default_nettype wire

/* src/sorted_key_list.sv */
// Top level of the sorted key list: request latch, row of key cells, result register.
`default_nettype none

// Sorted key list. Holds up to CAPACITY signed KEY_BITS-bit keys in ascending
// order in a row of cells, one key per cell. Each request item inserts (op 0),
// removes (op 1) or searches (op 2 or 3) one key; every item yields exactly one
// response item with status (0 ok, 1 full, 2 not found), found, position (first
// equal key or insert point, saturated at 15) and count (saturated at 31).
// An accepted item is held in a request register until the response register can take
// it; then all cells compare it in parallel and shift their keys at the same clock edge
// that registers the response, so rsp_valid rises at that edge; a new item is taken
// every cycle while rsp_stall stays low.
// The response register lets the next item be accepted
// while a finished response waits. Keys in empty cells are not cleared at reset.
module sorted_key_list #(
   parameter int CAPACITY = skl_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = skl_pkg::KEY_BITS_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [1:0]                req_op,
   input  wire  signed [KEY_BITS-1:0] req_key,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_found,
   output logic [3:0]                rsp_position,
   output logic [4:0]                rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > 5) ? CW : 5;

   logic                       busy_ff, busy_in;
   logic [1:0]                 op_ff;
   logic signed [KEY_BITS-1:0] probe_ff;
   logic [CW-1:0]              count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 status_ff;
   logic                       found_ff;
   logic [3:0]                 position_ff;
   logic [4:0]                 rcount_ff;

   logic                       fire;
   logic                       accept;
   logic                       full;
   logic                       hit;
   logic                       ins_ok;
   logic                       rem_ok;
   logic [CW-1:0]              pos;
   logic [CW-1:0]              enc;
   logic [SW-1:0]              pos_wide;
   logic [SW-1:0]              cnt_wide;
   logic [1:0]                 status;
   skl_pkg::cmd_type           cmd;

   logic signed [KEY_BITS-1:0] key_vec [CAPACITY];
   skl_pkg::flag_type          flag_vec [CAPACITY];
   logic [CAPACITY-1:0]        hit_vec;

   // Handshake: compute when a held item can move into the response register
   assign fire      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy_ff && !fire;
   assign accept    = req_valid && !req_stall;

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic occ;
      logic left_lt;
      logic signed [KEY_BITS-1:0] left_key;
      logic signed [KEY_BITS-1:0] right_key;

      assign occ = count_ff > CW'(i);
      if (i == 0) begin : g_first
         assign left_lt  = 1'b1;
         assign left_key = probe_ff;
      end else begin : g_mid
         assign left_lt  = flag_vec[i-1].lt;
         assign left_key = key_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_key = key_vec[i];
      end else begin : g_inner
         assign right_key = key_vec[i+1];
      end
      assign hit_vec[i] = flag_vec[i].hit;

      skl_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .probe_key (probe_ff),
         .occ       (occ),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .key_out   (key_vec[i]),
         .flags     (flag_vec[i])
      );
   end

   // Encode the one-hot insert point
   always_comb begin
      enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (flag_vec[i].at_pos) begin
            enc = enc | CW'(i);
         end
      end
   end

   assign hit  = |hit_vec;
   assign full = count_ff == CW'(CAPACITY);
   assign pos  = flag_vec[CAPACITY-1].lt ? CW'(CAPACITY) : enc;

   assign ins_ok  = fire && (op_ff == skl_pkg::OP_INSERT) && !full;
   assign rem_ok  = fire && (op_ff == skl_pkg::OP_REMOVE) && hit;
   assign cmd.ins = ins_ok;
   assign cmd.rem = rem_ok;

   // Next count and status
   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + CW'(1);
      end else if (rem_ok) begin
         count_in = count_ff - CW'(1);
      end
      case (op_ff)
         skl_pkg::OP_INSERT: status = full ? skl_pkg::ST_FULL : skl_pkg::ST_OK;
         default:            status = hit ? skl_pkg::ST_OK : skl_pkg::ST_MISSING;
      endcase
   end

   assign pos_wide = SW'(pos);
   assign cnt_wide = SW'(count_in);

   // Control next state
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (fire) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // Hold the accepted item and the finished response
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         probe_ff <= req_key;
      end
      if (fire) begin
         status_ff   <= status;
         found_ff    <= hit;
         position_ff <= (pos_wide > SW'(15)) ? 4'd15 : pos_wide[3:0];
         rcount_ff   <= (cnt_wide > SW'(31)) ? 5'd31 : cnt_wide[4:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = rcount_ff;

endmodule

`default_nettype wire

/* src/skl_cell.sv */
// One slot of the sorted key list: holds a key, compares it, shifts with its neighbors.
`default_nettype none

module skl_cell #(
   parameter int KEY_BITS = skl_pkg::KEY_BITS_DEF
) (
   input  wire                       clock,
   input  skl_pkg::cmd_type          cmd,
   input  wire signed [KEY_BITS-1:0] probe_key,
   input  wire                       occ,
   input  wire                       left_lt,
   input  wire signed [KEY_BITS-1:0] left_key,
   input  wire signed [KEY_BITS-1:0] right_key,
   output logic signed [KEY_BITS-1:0] key_out,
   output skl_pkg::flag_type         flags
);

   logic signed [KEY_BITS-1:0] key_ff;
   logic signed [KEY_BITS-1:0] key_in;
   logic                       lt;
   logic                       at_pos;

   // Compare stored key against the probe key
   assign lt     = occ && (key_ff < probe_key);
   assign at_pos = !lt && left_lt;

   assign flags.lt     = lt;
   assign flags.at_pos = at_pos;
   assign flags.hit    = at_pos && occ && (key_ff == probe_key);
   assign key_out      = key_ff;

   // Shift right on insert, left on remove; smaller keys hold
   always_comb begin
      key_in = key_ff;
      if (cmd.ins && !lt) begin
         key_in = at_pos ? probe_key : left_key;
      end else if (cmd.rem && !lt) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

/* tb/sv/sorted_key_list_tb.sv */
// Self-checking testbench for the sorted key list: directed and random traffic.
`timescale 1ns / 100ps

module sorted_key_list_tb;

   localparam int CAPACITY = skl_pkg::CAPACITY_DEF;
   localparam int KEY_BITS = skl_pkg::KEY_BITS_DEF;

   // Search codes are not part of the package
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   localparam int RANDOM_ITEMS = 1700;
   localparam int QUIET_ITEMS  = 300;
   localparam int IDLE_LIMIT   = 2000;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [3:0] position;
      logic [4:0] count;
   } lookup_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_op = skl_pkg::OP_INSERT;
   logic signed [KEY_BITS-1:0] req_key = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_status;
   logic                       rsp_found;
   logic [3:0]                 rsp_position;
   logic [4:0]                 rsp_count;

   // Shadow copy of the sorted store
   logic signed [KEY_BITS-1:0] shadow_keys [CAPACITY];
   int                         shadow_count = 0;

   lookup_result_type          pending_results[$];
   int                         errors = 0;
   int                         items_sent = 0;
   int                         results_checked = 0;
   int                         full_refusals = 0;
   int                         key_misses = 0;
   bit                         send_idling = 1'b1;
   bit                         rsp_idling = 1'b1;

   sorted_key_list #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one operation to the shadow store and return what the block must report
   function automatic lookup_result_type apply_op(input logic [1:0] op,
                                                  input logic signed [KEY_BITS-1:0] key);
      lookup_result_type r;
      int                pos;
      int                i;
      logic              hit;
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] < key) pos++;
      hit = (pos < shadow_count) && (shadow_keys[pos] == key);
      r.found = hit;
      if (op == skl_pkg::OP_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            r.status = skl_pkg::ST_FULL;
         end else begin
            for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[pos] = key;
            shadow_count++;
            r.status = skl_pkg::ST_OK;
         end
      end else if (op == skl_pkg::OP_REMOVE) begin
         if (hit) begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_count--;
            r.status = skl_pkg::ST_OK;
         end else begin
            r.status = skl_pkg::ST_MISSING;
         end
      end else begin
         r.status = hit ? skl_pkg::ST_OK : skl_pkg::ST_MISSING;
      end
      r.position = (pos > 15) ? 4'd15 : 4'(pos);
      r.count    = (shadow_count > 31) ? 5'd31 : 5'(shadow_count);
      return r;
   endfunction

   // Drive one item, hold it until accepted, then record its expected result
   task automatic send_item(input logic [1:0] op, input logic signed [KEY_BITS-1:0] key);
      lookup_result_type want;
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = apply_op(op, key);
      pending_results.push_back(want);
      items_sent++;
      if (want.status == skl_pkg::ST_FULL) full_refusals++;
      if (want.status == skl_pkg::ST_MISSING) key_misses++;
      if (send_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Pick a key: stored keys and their neighbors, small keys near zero, some extremes and full-range noise
   function automatic logic signed [KEY_BITS-1:0] pick_key();
      logic signed [KEY_BITS-1:0] k;
      int                         sel;
      sel = $urandom_range(0, 9);
      if (sel <= 3 && shadow_count > 0) begin
         k = shadow_keys[$urandom_range(0, shadow_count - 1)];
         if ($urandom_range(0, 3) == 0) k = k + $signed($urandom_range(0, 2)) - 1;
      end else if (sel <= 6) begin
         k = $signed($urandom_range(0, 7)) - 4;
      end else if (sel == 7) begin
         case ($urandom_range(0, 3))
            0: k = 32'sh7fffffff;
            1: k = 32'sh80000000;
            2: k = 32'sh00000000;
            default: k = 32'shffffffff;
         endcase
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   // Random mix of operations in phases that each favour filling, balance or draining the store
   task automatic run_random_phases(input int item_total);
      int target;
      int phase_len;
      int ins_pct;
      int rem_pct;
      int r;
      int j;
      target = items_sent + item_total;
      while (items_sent < target) begin
         phase_len = $urandom_range(60, 140);
         case ($urandom_range(0, 2))
            0: begin ins_pct = 70; rem_pct = 15; end
            1: begin ins_pct = 40; rem_pct = 35; end
            default: begin ins_pct = 15; rem_pct = 70; end
         endcase
         for (j = 0; j < phase_len && items_sent < target; j++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) send_item(skl_pkg::OP_INSERT, pick_key());
            else if (r < ins_pct + rem_pct) send_item(skl_pkg::OP_REMOVE, pick_key());
            else send_item(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_SEARCH, pick_key());
         end
      end
   endtask

   // Lookups and removes on an empty store
   task automatic test_empty_list();
      send_item(OP_SEARCH, 32'sh00000000);
      send_item(skl_pkg::OP_REMOVE, 32'sh80000000);
      send_item(OP_SPARE, 32'shffffffff);
   endtask

   // Extreme keys, a duplicate, removal of the first equal key
   task automatic test_extreme_keys();
      send_item(skl_pkg::OP_INSERT, 32'sh7fffffff);
      send_item(skl_pkg::OP_INSERT, 32'sh80000000);
      send_item(skl_pkg::OP_INSERT, 32'sh00000000);
      send_item(skl_pkg::OP_INSERT, 32'sh00000000);
      send_item(skl_pkg::OP_INSERT, 32'shffffffff);
      send_item(skl_pkg::OP_INSERT, 32'sh00000001);
      send_item(OP_SEARCH, 32'sh00000000);
      send_item(OP_SEARCH, 32'sh00000002);
      send_item(skl_pkg::OP_REMOVE, 32'sh00000000);
      send_item(OP_SPARE, 32'sh7fffffff);
      send_item(skl_pkg::OP_REMOVE, 32'sh80000000);
      send_item(OP_SEARCH, 32'sh80000000);
   endtask

   // Fill the store, refuse inserts when full, saturate the insert point
   task automatic test_full_list();
      int k;
      k = 1;
      while (shadow_count < CAPACITY) begin
         send_item(skl_pkg::OP_INSERT, k * 1000);
         k++;
      end
      send_item(skl_pkg::OP_INSERT, 32'sh7fffffff);
      send_item(skl_pkg::OP_REMOVE, 32'sh7fffffff);
      send_item(skl_pkg::OP_INSERT, 32'sh00001388);
      send_item(OP_SEARCH, 32'sh7fffffff);
      send_item(skl_pkg::OP_INSERT, 32'sh80000000);
   endtask

   task automatic test_random_traffic();
      send_idling = 1'b1;
      rsp_idling  = 1'b1;
      run_random_phases(RANDOM_ITEMS);
   endtask

   // Back-to-back items with no idling on either side
   task automatic test_back_to_back();
      send_idling = 1'b0;
      rsp_idling  = 1'b0;
      run_random_phases(QUIET_ITEMS);
   endtask

   // Reset, stimulus, drain and final report
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_extreme_keys();
      test_full_list();
      test_random_traffic();
      test_back_to_back();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d items over insert, remove and search, including spare op code,",
               items_sent);
      $display("  checked %0d results: %0d refused as full, %0d keys not found.",
               results_checked, full_refusals, key_misses);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Random backpressure on the result side in bursts
   initial begin : rsp_backpressure
      int len;
      bit hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!rsp_idling) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            len  = $urandom_range(1, 16);
            hold = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0) begin
               hold = 1'b0;
               len  = $urandom_range(40, 120);
            end
            rsp_stall <= hold;
            repeat (len) @(posedge clock);
         end
      end
   end

   function automatic void report_field(input string name, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_rsp
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                     $time, rsp_status, rsp_count);
            errors++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_status !== want.status) report_field("status", want.status, rsp_status);
            if (rsp_found !== want.found) report_field("found", want.found, rsp_found);
            if (rsp_position !== want.position)
               report_field("position", want.position, rsp_position);
            if (rsp_count !== want.count) report_field("count", want.count, rsp_count);
         end
      end
   end

   // End the run when nothing moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sorted_key_list.f */
src/skl_pkg.sv
src/skl_cell.sv
src/sorted_key_list.sv
tb/sv/sorted_key_list_tb.sv
